[sv/swrp_pkg.sv]
// Shared constants and types of the sliding window rank pattern block.
`default_nettype none

package swrp_pkg;

   localparam int MAX_ORDER_DEF   = 8;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int CSR_W           = 4;

   localparam logic [CSR_W-1:0] WINDOW_LEN_RST = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_RB_A,
      ST_RB_V,
      ST_RB_B,
      ST_DROP,
      ST_DROPV,
      ST_SWEEP,
      ST_NEW
   } state_type;

endpackage

`default_nettype wire

[sv/sliding_window_rank_pattern.sv]
// Top level: sliding window rank pattern, sample and rank memories with sequencer.
//
// Input channel req_: one signed sample per beat, req_restart clears the window first.
// Result channel rsp_: once the window holds window_len samples, every sample gives
// window_len beats, position 0 (oldest) first, each with that position's rank;
// rsp_last marks the final beat of the pattern.
// csr_: write of window_len (clamped to 2..MAX_ORDER), always ready; write only when idle.
// Ranks are kept in a rank memory beside the sample ring and updated per sample by
// removing the dropped sample's comparison and adding the new one's. Each sample passes
// through setup (accept, prepare, drop read), a step to take the dropped sample when
// one leaves the window, one cycle per surviving sample unless the receiver stalls
// (one memory read each, the read port sets the pace), a step to drain the last read
// and one to store the new sample. No further sample is accepted until it is stored.
// The first sample after a csr write rebuilds the ranks of the held window first. A
// stalled receiver holds the sweep; the output register keeps its beat until taken,
// and a new sample is accepted while it waits.
// Reset empties the window and sets window_len to 8; memories are not cleared.
`default_nettype none

module sliding_window_rank_pattern #(
   parameter int MAX_ORDER   = swrp_pkg::MAX_ORDER_DEF,
   parameter int SAMPLE_BITS = swrp_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0]     req_sample,
   input  wire logic                              req_restart,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [$clog2(MAX_ORDER)-1:0]           rsp_position,
   output logic [$clog2(MAX_ORDER)-1:0]           rsp_rank,
   output logic                                   rsp_last,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [swrp_pkg::CSR_W-1:0]        csr_window_len
);

   localparam int PW = $clog2(MAX_ORDER);
   localparam int CW = $clog2(MAX_ORDER + 1);
   localparam int XW = (CW > swrp_pkg::CSR_W) ? CW : swrp_pkg::CSR_W;

   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] ptr,
                                             input logic [CW-1:0] n,
                                             input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(ptr) + (CW+1)'(MAX_ORDER) - (CW+1)'(n) + (CW+1)'(k);
      if (s >= (CW+1)'(MAX_ORDER)) begin
         s = s - (CW+1)'(MAX_ORDER);
      end
      return PW'(s);
   endfunction

   swrp_pkg::state_type state_ff, state_in;

   logic [swrp_pkg::CSR_W-1:0] len_ff;
   logic                       rebuild_ff, rebuild_in;
   logic [SAMPLE_BITS-1:0]     x_ff, x_in;
   logic [PW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]              fill_ff, fill_in;
   logic [PW-1:0]              idx_ff, idx_in;
   logic [PW-1:0]              cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0]     drop_val_ff, drop_val_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [PW-1:0]              rd_idx_ff, rd_idx_in;
   logic [PW-1:0]              rd_slot_ff, rd_slot_in;
   logic [PW-1:0]              a_ff, a_in;
   logic [PW-1:0]              b_ff, b_in;
   logic [SAMPLE_BITS-1:0]     va_ff, va_in;
   logic [PW-1:0]              acc_ff, acc_in;

   logic [SAMPLE_BITS-1:0]     samp_mem_ff [MAX_ORDER];
   logic [PW-1:0]              rank_mem_ff [MAX_ORDER];
   logic [SAMPLE_BITS-1:0]     samp_rd_ff;
   logic [PW-1:0]              rank_rd_ff;

   logic                       rsp_valid_ff;
   logic [PW-1:0]              rsp_position_ff;
   logic [PW-1:0]              rsp_rank_ff;
   logic                       rsp_last_ff;

   logic [XW-1:0]              len_x;
   logic [CW-1:0]              eff_len, n_c, m_c;
   logic                       drop_c, emit_c, out_free;

   logic                       rd_en, samp_we, rank_we;
   logic [PW-1:0]              rd_addr, rank_wa, rank_wd;
   logic                       out_load, out_last;
   logic [PW-1:0]              out_pos, out_rank;
   logic                       rb_hit, consume, issue, d_hit, n_hit;
   logic [PW-1:0]              acc_sum, upd_rank;
   logic [PW:0]                upd_wide;

   always_comb begin
      len_x = XW'(len_ff);
      if (len_x < XW'(2)) begin
         eff_len = CW'(2);
      end else if (len_x > XW'(MAX_ORDER)) begin
         eff_len = CW'(MAX_ORDER);
      end else begin
         eff_len = CW'(len_x);
      end
      n_c      = (fill_ff < eff_len) ? fill_ff : eff_len;
      m_c      = (fill_ff < eff_len) ? fill_ff : eff_len - CW'(1);
      drop_c   = (fill_ff >= eff_len);
      emit_c   = (fill_ff >= eff_len - CW'(1));
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rb_hit = 1'b0;
      if (b_ff < a_ff) begin
         rb_hit = ($signed(samp_rd_ff) <= $signed(va_ff));
      end else if (b_ff > a_ff) begin
         rb_hit = ($signed(samp_rd_ff) < $signed(va_ff));
      end
      acc_sum  = acc_ff + PW'(rb_hit);
      d_hit    = drop_c && ($signed(drop_val_ff) <= $signed(samp_rd_ff));
      n_hit    = ($signed(x_ff) < $signed(samp_rd_ff));
      upd_wide = {1'b0, rank_rd_ff} - (PW+1)'(d_hit) + (PW+1)'(n_hit);
      upd_rank = PW'(upd_wide);
   end

   assign req_ready = (state_ff == swrp_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in    = state_ff;
      rebuild_in  = rebuild_ff;
      x_in        = x_ff;
      wr_ptr_in   = wr_ptr_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      cnt_in      = cnt_ff;
      drop_val_in = drop_val_ff;
      rd_pend_in  = rd_pend_ff;
      rd_idx_in   = rd_idx_ff;
      rd_slot_in  = rd_slot_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      va_in       = va_ff;
      acc_in      = acc_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      samp_we     = 1'b0;
      rank_we     = 1'b0;
      rank_wa     = '0;
      rank_wd     = '0;
      out_load    = 1'b0;
      out_pos     = '0;
      out_rank    = '0;
      out_last    = 1'b0;
      consume     = 1'b0;
      issue       = 1'b0;

      case (state_ff)
         swrp_pkg::ST_IDLE: begin
            if (req_valid) begin
               x_in = req_sample;
               if (req_restart) begin
                  fill_in = '0;
               end
               state_in = swrp_pkg::ST_PREP;
            end
         end
         swrp_pkg::ST_PREP: begin
            if (rebuild_ff && (n_c >= CW'(2))) begin
               a_in     = '0;
               state_in = swrp_pkg::ST_RB_A;
            end else begin
               rebuild_in = 1'b0;
               state_in   = swrp_pkg::ST_DROP;
            end
         end
         swrp_pkg::ST_RB_A: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(wr_ptr_ff, n_c, CW'(a_ff));
            state_in = swrp_pkg::ST_RB_V;
         end
         swrp_pkg::ST_RB_V: begin
            va_in    = samp_rd_ff;
            acc_in   = '0;
            b_in     = '0;
            rd_en    = 1'b1;
            rd_addr  = slot_of(wr_ptr_ff, n_c, '0);
            state_in = swrp_pkg::ST_RB_B;
         end
         swrp_pkg::ST_RB_B: begin
            if (CW'(b_ff) == n_c - CW'(1)) begin
               rank_we = 1'b1;
               rank_wa = slot_of(wr_ptr_ff, n_c, CW'(a_ff));
               rank_wd = acc_sum;
               if (CW'(a_ff) == n_c - CW'(1)) begin
                  rebuild_in = 1'b0;
                  state_in   = swrp_pkg::ST_DROP;
               end else begin
                  a_in     = a_ff + PW'(1);
                  state_in = swrp_pkg::ST_RB_A;
               end
            end else begin
               acc_in  = acc_sum;
               b_in    = b_ff + PW'(1);
               rd_en   = 1'b1;
               rd_addr = slot_of(wr_ptr_ff, n_c, CW'(b_ff) + CW'(1));
            end
         end
         swrp_pkg::ST_DROP: begin
            cnt_in = '0;
            idx_in = '0;
            if (drop_c) begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(wr_ptr_ff, n_c, '0);
               state_in = swrp_pkg::ST_DROPV;
            end else begin
               state_in = swrp_pkg::ST_SWEEP;
            end
         end
         swrp_pkg::ST_DROPV: begin
            drop_val_in = samp_rd_ff;
            state_in    = swrp_pkg::ST_SWEEP;
         end
         swrp_pkg::ST_SWEEP: begin
            consume = rd_pend_ff && (!emit_c || out_free);
            if (consume) begin
               rank_we = 1'b1;
               rank_wa = rd_slot_ff;
               rank_wd = upd_rank;
               cnt_in  = cnt_ff + PW'($signed(samp_rd_ff) <= $signed(x_ff));
               if (emit_c) begin
                  out_load = 1'b1;
                  out_pos  = rd_idx_ff;
                  out_rank = upd_rank;
               end
            end
            issue = (CW'(idx_ff) < m_c) && (!rd_pend_ff || consume);
            if (issue) begin
               rd_en      = 1'b1;
               rd_addr    = slot_of(wr_ptr_ff, n_c, CW'(idx_ff) + CW'(drop_c));
               rd_slot_in = rd_addr;
               rd_idx_in  = idx_ff;
               idx_in     = idx_ff + PW'(1);
            end
            rd_pend_in = issue || (rd_pend_ff && !consume);
            if (!rd_pend_in) begin
               state_in = swrp_pkg::ST_NEW;
            end
         end
         swrp_pkg::ST_NEW: begin
            if (!emit_c || out_free) begin
               samp_we = 1'b1;
               rank_we = 1'b1;
               rank_wa = wr_ptr_ff;
               rank_wd = cnt_ff;
               if (emit_c) begin
                  out_load = 1'b1;
                  out_pos  = PW'(m_c);
                  out_rank = cnt_ff;
                  out_last = 1'b1;
               end
               wr_ptr_in = (wr_ptr_ff == PW'(MAX_ORDER - 1)) ? '0 : wr_ptr_ff + PW'(1);
               fill_in   = (fill_ff == CW'(MAX_ORDER)) ? fill_ff : fill_ff + CW'(1);
               state_in  = swrp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swrp_pkg::ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         rebuild_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= swrp_pkg::ST_IDLE;
         len_ff     <= swrp_pkg::WINDOW_LEN_RST;
         rebuild_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         fill_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rebuild_ff <= rebuild_in;
         wr_ptr_ff  <= wr_ptr_in;
         fill_ff    <= fill_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_valid) begin
            len_ff <= csr_window_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      drop_val_ff <= drop_val_in;
      rd_idx_ff   <= rd_idx_in;
      rd_slot_ff  <= rd_slot_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      va_ff       <= va_in;
      acc_ff      <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (samp_we) begin
         samp_mem_ff[wr_ptr_ff] <= x_ff;
      end
      if (rd_en) begin
         samp_rd_ff <= samp_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem_ff[rank_wa] <= rank_wd;
      end
      if (rd_en) begin
         rank_rd_ff <= rank_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_position_ff <= out_pos;
         rsp_rank_ff     <= out_rank;
         rsp_last_ff     <= out_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_rank     = rsp_rank_ff;
   assign rsp_last     = rsp_last_ff;

   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == swrp_pkg::ST_SWEEP))
      else $error("read pending outside sweep");

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == swrp_pkg::ST_PREP))
      else $error("accepted sample not taken into setup");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ORDER))
      else $error("fill count beyond window depth");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("held result beat overwritten");

   a_sweep_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swrp_pkg::ST_SWEEP) |-> (CW'(idx_ff) <= m_c))
      else $error("sweep index past survivors");

endmodule

`default_nettype wire
